// ===== rtl/core/bab_pkg.sv =====
`timescale 1ns / 1ps

package bab_pkg;

  localparam int MAX_TRACKS_DEF = 255;
  localparam int WORD_BITS_DEF  = 64;
  localparam int SECTORS        = 256;

  localparam logic [1:0] FN_ALLOC  = 2'd0;
  localparam logic [1:0] FN_FREE   = 2'd1;
  localparam logic [1:0] FN_FIND   = 2'd2;
  localparam logic [1:0] FN_FORMAT = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ALLOCATED = 3'd1;
  localparam logic [2:0] ST_FREE      = 3'd2;
  localparam logic [2:0] ST_NONE      = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] track;
    logic [7:0] sector;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  free_track;
    logic [7:0]  free_sector;
    logic [15:0] free_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_FMT
  } bab_state_e;

endpackage

// ===== rtl/core/bab_ram.sv =====
`timescale 1ns / 1ps

module bab_ram #(
  parameter int DW    = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/block_allocation_bitmap_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake            Payload       Notes
// -------   ------------------   -----------   ---------------------------------
// request   start_i / busy_o     req_i         beat taken when start_i & !busy_o
// result    done_o (strobe)      rsp_o         valid for one cycle, cannot stall
// config    cfg_we_i             cfg_wdata_i   track_count, write only while idle
//
// Sequence from accept to result: allocate/free read the bitmap word, then
// modify and write it back; a track out of range is answered straight from
// idle. Find scans one bitmap word per cycle from track 1 up, set by the single
// read port; an allocate of a taken sector runs the same scan. Format rewrites
// every word, one per cycle.
// Reset: a sweep of every word clears the bitmap, busy_o high meanwhile.

module block_allocation_bitmap_unit #(
  parameter int MAX_TRACKS = bab_pkg::MAX_TRACKS_DEF,
  parameter int WORD_BITS  = bab_pkg::WORD_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  bab_pkg::req_t req_i,
  output logic          done_o,
  output bab_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i
);

  import bab_pkg::*;

  localparam int WPT       = SECTORS / WORD_BITS;      // words per track
  localparam int WPTB      = $clog2(WPT);
  localparam int SB        = $clog2(WORD_BITS);        // bit index width
  localparam int NUM_WORDS = (MAX_TRACKS + 1) * WPT;
  localparam int AW        = $clog2(NUM_WORDS);

  localparam logic [AW-1:0] LAST_WORD  = AW'(NUM_WORDS - 1);
  localparam logic [AW-1:0] FIRST_SCAN = AW'(WPT);     // track 1, word 0

  // Lowest set bit of a nonzero word.
  function automatic logic [SB-1:0] low_idx(input logic [WORD_BITS-1:0] w);
    logic [SB-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = SB'(i);
    end
    return idx;
  endfunction

  bab_state_e state_q, state_d;
  req_t       req_q, req_d;
  rsp_t       rsp_q, rsp_d;
  logic       done_q, done_d;
  logic [7:0] tcount_q;
  logic [15:0] total_q, total_d;
  logic [AW-1:0] addr_q, addr_d;        // sweep / scan issue pointer
  logic          issue_done_q, issue_done_d;
  logic          rd_vld_q, rd_vld_d;    // a scan read returns this cycle
  logic [AW-1:0] rd_addr_q, rd_addr_d;

  // bitmap port
  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  bab_ram #(
    .DW    (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // tracks in use, clamped to the table size
  logic [7:0]    n_trk;
  logic          in_range;
  logic [AW-1:0] req_word, cur_word, last_scan;
  logic [8:0]    fmt_lim;               // format allocates track 1 sectors 0..fmt_lim
  logic [15:0]   fmt_total;
  logic [7:0]    sweep_trk;
  logic [WORD_BITS-1:0] fmt_word, bit_mask;
  logic          cur_bit;

  assign n_trk    = (32'(tcount_q) > MAX_TRACKS) ? 8'(MAX_TRACKS) : tcount_q;
  assign in_range = (req_i.track != 8'd0) && (req_i.track <= n_trk);
  assign req_word = AW'((32'(req_i.track) << WPTB) + (32'(req_i.sector) >> SB));
  assign cur_word = AW'((32'(req_q.track) << WPTB) + (32'(req_q.sector) >> SB));
  assign last_scan = AW'(((32'(n_trk) + 32'd1) << WPTB) - 32'd1);
  assign fmt_lim   = 9'd2 + 9'(tcount_q >> 3);
  assign fmt_total = (n_trk == 8'd0) ? 16'd0 : ({n_trk, 8'h00} - (16'(fmt_lim) + 16'd1));
  assign sweep_trk = 8'(addr_q >> WPTB);
  assign bit_mask  = WORD_BITS'(1) << req_q.sector[SB-1:0];
  assign cur_bit   = rdata[req_q.sector[SB-1:0]];

  // format image of the word at addr_q
  always_comb begin
    logic [8:0] sec;
    sec      = '0;
    fmt_word = '0;
    if (sweep_trk != 8'd0 && sweep_trk <= n_trk) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        sec = 9'(((32'(addr_q) & (WPT - 1)) << SB) + b);
        fmt_word[b] = !((sweep_trk == 8'd1) && (sec <= fmt_lim));
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    done_d       = 1'b0;
    total_d      = total_q;
    addr_d       = addr_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = 1'b0;
    rd_addr_d    = rd_addr_q;
    rsp_d        = '0;
    we           = 1'b0;
    waddr        = addr_q;
    wdata        = '0;
    re           = 1'b0;
    raddr        = addr_q;

    unique case (state_q)
      S_INIT: begin
        we     = 1'b1;
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST_WORD) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          unique case (req_i.func)
            FN_ALLOC, FN_FREE: begin
              if (!in_range) begin
                done_d       = 1'b1;
                rsp_d.status = ST_RANGE;
              end else begin
                re      = 1'b1;
                raddr   = req_word;
                state_d = S_RMW;
              end
            end
            FN_FIND: begin
              if (n_trk == 8'd0) begin
                done_d       = 1'b1;
                rsp_d.status = ST_NONE;
              end else begin
                addr_d       = FIRST_SCAN;
                issue_done_d = 1'b0;
                state_d      = S_SCAN;
              end
            end
            FN_FORMAT: begin
              addr_d  = '0;
              state_d = S_FMT;
            end
            default: ;
          endcase
        end
      end

      S_RMW: begin
        waddr = cur_word;
        if (req_q.func == FN_ALLOC) begin
          if (cur_bit) begin
            we      = 1'b1;
            wdata   = rdata & ~bit_mask;
            total_d = total_q - 16'd1;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            // taken already: report the lowest free block
            addr_d       = FIRST_SCAN;
            issue_done_d = 1'b0;
            state_d      = S_SCAN;
          end
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (!cur_bit) begin
            we      = 1'b1;
            wdata   = rdata | bit_mask;
            total_d = total_q + 16'd1;
          end else begin
            rsp_d.status = ST_FREE;
          end
        end
      end

      S_SCAN: begin
        if (!issue_done_q) begin
          re        = 1'b1;
          raddr     = addr_q;
          rd_vld_d  = 1'b1;
          rd_addr_d = addr_q;
          if (addr_q == last_scan) issue_done_d = 1'b1;
          else addr_d = addr_q + AW'(1);
        end
        if (rd_vld_q) begin
          if (rdata != '0) begin
            done_d            = 1'b1;
            rd_vld_d          = 1'b0;
            state_d           = S_IDLE;
            rsp_d.status      = (req_q.func == FN_ALLOC) ? ST_ALLOCATED : ST_OK;
            rsp_d.free_track  = 8'(rd_addr_q >> WPTB);
            rsp_d.free_sector = 8'(((32'(rd_addr_q) & (WPT - 1)) << SB)
                                   | 32'(low_idx(rdata)));
          end else if (rd_addr_q == last_scan) begin
            done_d       = 1'b1;
            rd_vld_d     = 1'b0;
            state_d      = S_IDLE;
            rsp_d.status = (req_q.func == FN_ALLOC) ? ST_ALLOCATED : ST_NONE;
          end
        end
      end

      S_FMT: begin
        we     = 1'b1;
        wdata  = fmt_word;
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST_WORD) begin
          addr_d  = '0;
          total_d = fmt_total;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    rsp_d.free_count = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      done_q       <= 1'b0;
      total_q      <= '0;
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      tcount_q     <= 8'hff;
    end else begin
      state_q      <= state_d;
      done_q       <= done_d;
      total_q      <= total_d;
      addr_q       <= addr_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      if (cfg_we_i) tcount_q <= cfg_wdata_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rsp_q     <= rsp_d;
    rd_addr_q <= rd_addr_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
